// ----- rtl/bid_pkg.sv -----
`timescale 1ns / 1ps
package bid_pkg;

  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_READ_POS  = 3'd4,
    OP_READ_BACK = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  // status of one item, carried alongside the memory read
  typedef struct packed {
    logic               rd;
    logic               error;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
  } res_meta_t;

endpackage

// ----- rtl/bounded_int_deque_core.sv -----
`timescale 1ns / 1ps
// path: an accepted item passes the memory read stage, then the output register, to m_tvalid
// throughput: one item per cycle while results are taken; the memory read
//   stage holds one item when the output register is full
// reset: front pointer and count go to zero, no result pending; the entry
//   memory is not cleared and needs no sweep
module bounded_int_deque_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // func[2:0], data_in[34:3], position[40:35], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // data_out[31:0], error[32], is_empty[33],
                                // entry_count[40:34], zero fill
);
  import bid_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OUT_W = DATA_W + 2 + COUNT_W;

  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [POS_W-1:0]  position;

  logic              accept;
  logic              load;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] rdata;
  res_meta_t         meta;

  logic              pend;
  res_meta_t         pend_meta;
  logic [OUT_W-1:0]  out_word;

  assign func     = s_tdata[FUNC_W-1:0];
  assign data_in  = s_tdata[FUNC_W+DATA_W-1:FUNC_W];
  assign position = s_tdata[FUNC_W+DATA_W+POS_W-1:FUNC_W+DATA_W];

  assign load     = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || load;
  assign accept   = s_tvalid && s_tready;

  bid_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .position(position),
    .mem_we  (mem_we),
    .mem_re  (mem_re),
    .mem_addr(mem_addr),
    .meta    (meta)
  );

  bid_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(data_in),
    .rdata(rdata)
  );

  // read stage: status waits here for the memory data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_meta <= meta;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= {pend_meta.entry_count, pend_meta.is_empty, pend_meta.error,
                   (pend_meta.rd ? rdata : DATA_W'(0))};
    end
  end

  assign m_tdata = {(48 - OUT_W)'(0), out_word};

  a_accept_pend: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> pend)
    else $error("accepted item not held in read stage");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    pend && m_tvalid && !m_tready |=> pend)
    else $error("read stage dropped an item under stall");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[DATA_W] |-> m_tdata[DATA_W-1:0] == '0)
    else $error("error result carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[DATA_W+1] |-> m_tdata[OUT_W-1:DATA_W+2] == '0)
    else $error("empty result with nonzero count");

endmodule

// ----- rtl/bid_ram.sv -----
`timescale 1ns / 1ps
module bid_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [bid_pkg::DATA_W-1:0] wdata,
  output logic [bid_pkg::DATA_W-1:0] rdata
);
  import bid_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/bid_ctrl.sv -----
`timescale 1ns / 1ps
module bid_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [bid_pkg::FUNC_W-1:0]  func,
  input  logic [bid_pkg::POS_W-1:0]   position,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_addr,
  output bid_pkg::res_meta_t          meta
);
  import bid_pkg::*;

  localparam int SW = CW + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [CW-1:0] offset;
  logic [SW-1:0] ring_sum;
  logic [AW-1:0] ring_addr;
  logic          is_full;
  logic          is_zero;
  logic          pos_bad;
  logic          we_op;
  logic          re_op;
  logic          err_op;
  logic          use_front;

  assign is_full   = (count == CW'(CAPACITY));
  assign is_zero   = (count == '0);
  assign pos_bad   = (PW'(position) >= PW'(count));
  assign front_dec = (front == '0) ? AW'(CAPACITY - 1) : front - AW'(1);
  assign front_inc = (front == AW'(CAPACITY - 1)) ? '0 : front + AW'(1);

  // single ring adder, wraps with one compare and subtract
  assign ring_sum  = SW'(front) + SW'(offset);
  assign ring_addr = (ring_sum >= SW'(CAPACITY)) ? AW'(ring_sum - SW'(CAPACITY))
                                                 : AW'(ring_sum);

  always_comb begin
    front_next = front;
    count_next = count;
    offset     = count - CW'(1);
    we_op      = 1'b0;
    re_op      = 1'b0;
    err_op     = 1'b0;
    use_front  = 1'b0;
    case (func)
      OP_ADD_FRONT: begin
        if (is_full) begin
          err_op = 1'b1;
        end else begin
          front_next = front_dec;
          count_next = count + CW'(1);
          we_op      = 1'b1;
          use_front  = 1'b1;
        end
      end
      OP_ADD_BACK: begin
        offset = count;
        if (is_full) begin
          err_op = 1'b1;
        end else begin
          count_next = count + CW'(1);
          we_op      = 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (is_zero) begin
          err_op = 1'b1;
        end else begin
          front_next = front_inc;
          count_next = count - CW'(1);
          re_op      = 1'b1;
          use_front  = 1'b1;
        end
      end
      OP_REM_BACK: begin
        if (is_zero) begin
          err_op = 1'b1;
        end else begin
          count_next = count - CW'(1);
          re_op      = 1'b1;
        end
      end
      OP_READ_POS: begin
        offset = CW'(PW'(position));
        if (pos_bad) begin
          err_op = 1'b1;
        end else begin
          re_op = 1'b1;
        end
      end
      OP_READ_BACK: begin
        if (is_zero) begin
          err_op = 1'b1;
        end else begin
          re_op = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
        err_op = 1'b1;
      end
    endcase
  end

  assign mem_we   = accept && we_op;
  assign mem_re   = accept && re_op;
  // add front writes the new front slot, remove front reads the old one
  assign mem_addr = use_front ? ((func == OP_ADD_FRONT) ? front_dec : front) : ring_addr;

  assign meta.rd          = re_op;
  assign meta.error       = err_op;
  assign meta.is_empty    = (count_next == '0);
  assign meta.entry_count = COUNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule
